// File: sv/bjv_pkg.sv
// ----------------------------------------------------------------------------
// bjv_pkg
// shared widths, register codes, pipeline payload types and output helpers
// for the ballistic jump velocity unit
// ----------------------------------------------------------------------------
package bjv_pkg;

    localparam int POS_W      = 23;
    localparam int DIF_W      = 24;
    localparam int VEL_W      = 24;
    localparam int CFG_W      = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 168;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HORZ_SPEED = 1'b1;

    localparam logic [CFG_W-1:0] GRAVITY_RST = 18'd204800;
    localparam logic [CFG_W-1:0] SPEED_RST   = 18'd89600;
    localparam logic [POS_W-1:0] H_CAP       = {POS_W{1'b1}};

    // hang height divider
    localparam int HANG_NW = 62;
    localparam int HANG_DW = 39;
    localparam int HANG_QW = 23;
    // square root lanes
    localparam int SQ_NW = 56;
    localparam int SQ_RW = SQ_NW / 2;
    // velocity and apex dividers
    localparam int TD_NW = 52;
    localparam int TD_DW = SQ_RW + 1;
    localparam int TD_QW = 24;

    localparam int FRONT_LAT = 6;
    localparam int PIPE_LAT  = FRONT_LAT + HANG_QW + 2 + SQ_RW + 3 + TD_QW;

    typedef struct packed {
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic signed [POS_W-1:0] sz;
        logic signed [DIF_W-1:0] dx;
        logic signed [DIF_W-1:0] dy;
        logic signed [DIF_W-1:0] step;
        logic [POS_W-1:0]        minh;
    } front_t;

    typedef struct packed {
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic signed [POS_W-1:0] sz;
        logic                    dx_neg;
        logic                    dy_neg;
        logic                    dx_nz;
        logic                    dy_nz;
        logic [POS_W-1:0]        dx_mag;
        logic [POS_W-1:0]        dy_mag;
        logic [POS_W-1:0]        h;
    } mid_t;

    typedef struct packed {
        mid_t             m;
        logic             s_zero;
        logic             ovx;
        logic             ovy;
        logic [SQ_RW-1:0] vz;
    } tail_t;

    typedef struct packed {
        logic [POS_W-1:0] used_height;
        logic [POS_W-1:0] apex_z;
        logic [POS_W-1:0] apex_y;
        logic [POS_W-1:0] apex_x;
        logic [POS_W-1:0] vel_z;
        logic [VEL_W-1:0] vel_y;
        logic [VEL_W-1:0] vel_x;
    } result_t;

    function automatic logic [VEL_W-1:0] horz_vel(
        input logic             neg,
        input logic             nz,
        input logic             s_zero,
        input logic             ovf,
        input logic [TD_QW-1:0] q
    );
        logic [VEL_W-1:0] pos_max;
        logic [VEL_W-1:0] neg_min;
        logic [VEL_W-1:0] res;
        pos_max = {1'b0, {(VEL_W-1){1'b1}}};
        neg_min = {1'b1, {(VEL_W-1){1'b0}}};
        if (s_zero) begin
            res = !nz ? '0 : (neg ? neg_min : pos_max);
        end else if (neg) begin
            res = (ovf || (VEL_W'(q) > neg_min)) ? neg_min : VEL_W'(-q);
        end else begin
            res = (ovf || (VEL_W'(q) > pos_max)) ? pos_max : VEL_W'(q);
        end
        return res;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [POS_W+1:0] v);
        logic signed [POS_W+1:0] lo;
        logic signed [POS_W+1:0] hi;
        logic [POS_W-1:0]        res;
        lo = -(25'sd1 <<< (POS_W-1));
        hi = (25'sd1 <<< (POS_W-1)) - 25'sd1;
        if (v < lo) begin
            res = {1'b1, {(POS_W-1){1'b0}}};
        end else if (v > hi) begin
            res = {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [POS_W-1:0] apex_pos(
        input logic                    s_zero,
        input logic                    neg,
        input logic signed [POS_W-1:0] s,
        input logic [TD_QW-1:0]        q
    );
        logic signed [POS_W+1:0] base;
        logic signed [POS_W+1:0] ofs;
        logic [POS_W-1:0]        res;
        base = {{2{s[POS_W-1]}}, s};
        ofs  = $signed({1'b0, q});
        if (s_zero) begin
            res = s;
        end else if (neg) begin
            res = clamp_pos(base - ofs);
        end else begin
            res = clamp_pos(base + ofs);
        end
        return res;
    endfunction

endpackage

// File: sv/bjv_div.sv
// ----------------------------------------------------------------------------
// bjv_div
// pipelined restoring divider, one quotient bit per stage, numerator must be
// below den shifted up by the quotient width
// ----------------------------------------------------------------------------
module bjv_div #(
    parameter int NW = bjv_pkg::HANG_NW,
    parameter int DW = bjv_pkg::HANG_DW,
    parameter int QW = bjv_pkg::HANG_QW
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [NW-1:0] sub;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (j == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_more
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign sub = NW'(den_in) << (QW - 1 - j);

        always_comb begin
            if (rem_in >= sub) begin
                rem_next = rem_in - sub;
                quo_next = quo_in | (QW'(1) << (QW - 1 - j));
            end else begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_in;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// File: sv/bjv_sqrt.sv
// ----------------------------------------------------------------------------
// bjv_sqrt
// pipelined integer square root, one root bit per stage, floor result
// ----------------------------------------------------------------------------
module bjv_sqrt #(
    parameter int NW = bjv_pkg::SQ_NW
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [NW-1:0]     rad,
    output logic [NW/2-1:0]   root
);

    localparam int RW = NW / 2;

    logic [NW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [NW-1:0] trial;
        logic [NW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (j == 0) begin : g_first
            assign rem_in  = rad;
            assign root_in = '0;
        end else begin : g_more
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        assign trial = (NW'(root_in) << (RW - j)) | (NW'(1) << (2 * (RW - 1 - j)));

        always_comb begin
            if (rem_in >= trial) begin
                rem_next  = rem_in - trial;
                root_next = root_in | (RW'(1) << (RW - 1 - j));
            end else begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

// File: sv/ballistic_jump_velocity_unit.sv
// ----------------------------------------------------------------------------
// ballistic_jump_velocity_unit
// Takes one jump request per cycle and returns its launch velocity, apex point
// and used apex height through a two-entry output buffer. The
// pipeline runs through the 23-stage hang height divider, the 28-stage square
// root lanes and the 24-stage velocity and apex dividers, all fully pipelined,
// so the sustained rate is one request per cycle as long as results are taken.
// Input is held off only when both output buffer entries are occupied.
// Registers: index 0 gravity, index 1 top horizontal speed; write them only
// while no request is in flight. A zero register value acts as one.
// ----------------------------------------------------------------------------
module ballistic_jump_velocity_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // start_x, start_y, start_z, goal_x, goal_y, goal_z, min_height
    input  logic [bjv_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vel_x, vel_y, vel_z, apex_x, apex_y, apex_z, used_height
    output logic [bjv_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bjv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bjv_pkg::CFG_W-1:0]       cfg_data
);

    localparam int PW = bjv_pkg::POS_W;
    localparam int DW = bjv_pkg::DIF_W;
    localparam int CW = bjv_pkg::CFG_W;
    localparam int LAT = bjv_pkg::PIPE_LAT;

    // configuration
    logic [CW-1:0] gravity_reg;
    logic [CW-1:0] speed_reg;
    logic [CW-1:0] g_eff;
    logic [CW-1:0] v_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= bjv_pkg::GRAVITY_RST;
            speed_reg   <= bjv_pkg::SPEED_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                bjv_pkg::CFG_GRAVITY:        gravity_reg <= cfg_data;
                bjv_pkg::CFG_MAX_HORZ_SPEED: speed_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign g_eff = (gravity_reg == '0) ? CW'(1) : gravity_reg;
    assign v_eff = (speed_reg == '0) ? CW'(1) : speed_reg;

    // flow control
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           en;
    logic           push;
    logic           pop;
    logic [LAT-1:0] vld_reg;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;
    assign push     = en && vld_reg[LAT-1];
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // front end: differences, squares, hang numerator
    logic [PW-1:0] sx_in, sy_in, sz_in, gx_in, gy_in, gz_in, minh_in;
    bjv_pkg::front_t front_next;
    bjv_pkg::front_t fr_reg [bjv_pkg::FRONT_LAT];

    assign sx_in   = s_tdata[0*PW +: PW];
    assign sy_in   = s_tdata[1*PW +: PW];
    assign sz_in   = s_tdata[2*PW +: PW];
    assign gx_in   = s_tdata[3*PW +: PW];
    assign gy_in   = s_tdata[4*PW +: PW];
    assign gz_in   = s_tdata[5*PW +: PW];
    assign minh_in = s_tdata[6*PW +: PW];

    always_comb begin
        front_next.sx   = sx_in;
        front_next.sy   = sy_in;
        front_next.sz   = sz_in;
        front_next.dx   = $signed({gx_in[PW-1], gx_in}) - $signed({sx_in[PW-1], sx_in});
        front_next.dy   = $signed({gy_in[PW-1], gy_in}) - $signed({sy_in[PW-1], sy_in});
        front_next.step = $signed({gz_in[PW-1], gz_in}) - $signed({sz_in[PW-1], sz_in});
        front_next.minh = minh_in;
    end

    logic signed [2*DW-1:0] sqx_full;
    logic signed [2*DW-1:0] sqy_full;
    logic [35:0] vv_next;
    logic [46:0] sqx_reg, sqy_reg;
    logic [35:0] vv_reg;
    logic [46:0] d2_reg;
    logic [38:0] den3_reg;
    logic [41:0] plo_next;
    logic [40:0] phi_next;
    logic [41:0] plo_reg;
    logic [40:0] phi_reg;
    logic [38:0] den4_reg;
    logic [65:0] num_reg;
    logic [38:0] den5_reg;
    logic        hov_reg;
    logic [bjv_pkg::HANG_NW-1:0] hnum_reg;
    logic [bjv_pkg::HANG_DW-1:0] hden_reg;

    assign sqx_full = fr_reg[0].dx * fr_reg[0].dx;
    assign sqy_full = fr_reg[0].dy * fr_reg[0].dy;
    assign vv_next  = v_eff * v_eff;
    assign plo_next = g_eff * d2_reg[23:0];
    assign phi_next = g_eff * d2_reg[46:24];

    always_ff @(posedge aclk) begin
        if (en) begin
            fr_reg[0] <= front_next;
            for (int k = 1; k < bjv_pkg::FRONT_LAT; k++) begin
                fr_reg[k] <= fr_reg[k-1];
            end
            sqx_reg  <= sqx_full[46:0];
            sqy_reg  <= sqy_full[46:0];
            vv_reg   <= vv_next;
            d2_reg   <= sqx_reg + sqy_reg;
            den3_reg <= {vv_reg, 3'b000};
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            den4_reg <= den3_reg;
            num_reg  <= 66'({phi_reg, 24'b0}) + 66'(plo_reg);
            den5_reg <= den4_reg;
            hov_reg  <= (num_reg >= 66'({den5_reg, 23'b0}));
            hnum_reg <= num_reg[bjv_pkg::HANG_NW-1:0];
            hden_reg <= den5_reg;
        end
    end

    // hang height division
    logic [bjv_pkg::HANG_QW-1:0] hq;
    bjv_pkg::front_t fd_reg  [bjv_pkg::HANG_QW];
    logic            hovd_reg [bjv_pkg::HANG_QW];

    bjv_div #(
        .NW (bjv_pkg::HANG_NW),
        .DW (bjv_pkg::HANG_DW),
        .QW (bjv_pkg::HANG_QW)
    ) u_div_hang (
        .aclk (aclk),
        .en   (en),
        .num  (hnum_reg),
        .den  (hden_reg),
        .quo  (hq)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            fd_reg[0]   <= fr_reg[bjv_pkg::FRONT_LAT-1];
            hovd_reg[0] <= hov_reg;
            for (int k = 1; k < bjv_pkg::HANG_QW; k++) begin
                fd_reg[k]   <= fd_reg[k-1];
                hovd_reg[k] <= hovd_reg[k-1];
            end
        end
    end

    // apex height selection
    bjv_pkg::front_t fh;
    logic [PW-1:0]      hang;
    logic [PW-1:0]      h_sel;
    logic signed [DW:0] e_full;
    bjv_pkg::mid_t      mid_next;
    bjv_pkg::mid_t      ha_reg;
    logic [DW-1:0]      hae_reg;

    assign fh   = fd_reg[bjv_pkg::HANG_QW-1];
    assign hang = hovd_reg[bjv_pkg::HANG_QW-1] ? bjv_pkg::H_CAP : hq;

    always_comb begin
        h_sel = fh.minh;
        if (hang > h_sel) begin
            h_sel = hang;
        end
        if (!fh.step[DW-1] && (fh.step[PW-1:0] > h_sel)) begin
            h_sel = fh.step[PW-1:0];
        end
        e_full = $signed({2'b00, h_sel}) - $signed({fh.step[DW-1], fh.step});

        mid_next.sx     = fh.sx;
        mid_next.sy     = fh.sy;
        mid_next.sz     = fh.sz;
        mid_next.dx_neg = fh.dx[DW-1];
        mid_next.dy_neg = fh.dy[DW-1];
        mid_next.dx_nz  = (fh.dx != '0);
        mid_next.dy_nz  = (fh.dy != '0);
        mid_next.dx_mag = fh.dx[DW-1] ? PW'(-fh.dx) : fh.dx[PW-1:0];
        mid_next.dy_mag = fh.dy[DW-1] ? PW'(-fh.dy) : fh.dy[PW-1:0];
        mid_next.h      = h_sel;
    end

    // root operands
    localparam int SN = bjv_pkg::SQ_NW;
    localparam int SR = bjv_pkg::SQ_RW;

    logic [CW+PW-1:0] gh_next;
    bjv_pkg::mid_t    hb_reg;
    logic [SN-1:0]    n0_reg, n1_reg, ng_reg, nv_reg;

    assign gh_next = g_eff * ha_reg.h;

    always_ff @(posedge aclk) begin
        if (en) begin
            ha_reg  <= mid_next;
            hae_reg <= e_full[DW-1:0];
            hb_reg  <= ha_reg;
            n0_reg  <= SN'({ha_reg.h, 32'b0});
            n1_reg  <= SN'({hae_reg, 32'b0});
            ng_reg  <= SN'({g_eff, 31'b0});
            nv_reg  <= SN'({gh_next, 1'b0});
        end
    end

    logic [SR-1:0] s0, s1, sg, vz;

    bjv_sqrt #(.NW(SN)) u_sqrt_rise (.aclk(aclk), .en(en), .rad(n0_reg), .root(s0));
    bjv_sqrt #(.NW(SN)) u_sqrt_fall (.aclk(aclk), .en(en), .rad(n1_reg), .root(s1));
    bjv_sqrt #(.NW(SN)) u_sqrt_grav (.aclk(aclk), .en(en), .rad(ng_reg), .root(sg));
    bjv_sqrt #(.NW(SN)) u_sqrt_velz (.aclk(aclk), .en(en), .rad(nv_reg), .root(vz));

    bjv_pkg::mid_t md_reg [SR];

    always_ff @(posedge aclk) begin
        if (en) begin
            md_reg[0] <= hb_reg;
            for (int k = 1; k < SR; k++) begin
                md_reg[k] <= md_reg[k-1];
            end
        end
    end

    // flight time sum, products, overflow checks
    localparam int TN = bjv_pkg::TD_NW;
    localparam int TDW = bjv_pkg::TD_DW;

    bjv_pkg::mid_t  sm_reg, mm_reg;
    logic [TDW-1:0] s_reg, ms_reg, os_reg;
    logic [SR-1:0]  s0_reg, sg_reg, vz_reg, mvz_reg;
    logic [PW+SR-1:0] pvx, pvy, pax, pay;
    logic [PW+SR-1:0] nvx_reg, nvy_reg, nax_reg, nay_reg;
    logic [TN-1:0]  vnx_reg, vny_reg, anx_reg, any_reg;
    bjv_pkg::tail_t ov_reg;

    assign pvx = sm_reg.dx_mag * sg_reg;
    assign pvy = sm_reg.dy_mag * sg_reg;
    assign pax = sm_reg.dx_mag * s0_reg;
    assign pay = sm_reg.dy_mag * s0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sm_reg  <= md_reg[SR-1];
            s_reg   <= TDW'(s0) + TDW'(s1);
            s0_reg  <= s0;
            sg_reg  <= sg;
            vz_reg  <= vz;

            mm_reg  <= sm_reg;
            ms_reg  <= s_reg;
            mvz_reg <= vz_reg;
            nvx_reg <= pvx;
            nvy_reg <= pvy;
            nax_reg <= pax;
            nay_reg <= pay;

            ov_reg.m      <= mm_reg;
            ov_reg.s_zero <= (ms_reg == '0);
            ov_reg.ovx    <= ((TN+1)'(nvx_reg) >= (TN+1)'({ms_reg, 24'b0}));
            ov_reg.ovy    <= ((TN+1)'(nvy_reg) >= (TN+1)'({ms_reg, 24'b0}));
            ov_reg.vz     <= mvz_reg;
            os_reg  <= ms_reg;
            vnx_reg <= TN'(nvx_reg);
            vny_reg <= TN'(nvy_reg);
            anx_reg <= TN'(nax_reg);
            any_reg <= TN'(nay_reg);
        end
    end

    // velocity and apex division
    localparam int TQ = bjv_pkg::TD_QW;

    logic [TQ-1:0] qvx, qvy, qax, qay;

    bjv_div #(.NW(TN), .DW(TDW), .QW(TQ)) u_div_vx (
        .aclk(aclk), .en(en), .num(vnx_reg), .den(os_reg), .quo(qvx));
    bjv_div #(.NW(TN), .DW(TDW), .QW(TQ)) u_div_vy (
        .aclk(aclk), .en(en), .num(vny_reg), .den(os_reg), .quo(qvy));
    bjv_div #(.NW(TN), .DW(TDW), .QW(TQ)) u_div_ax (
        .aclk(aclk), .en(en), .num(anx_reg), .den(os_reg), .quo(qax));
    bjv_div #(.NW(TN), .DW(TDW), .QW(TQ)) u_div_ay (
        .aclk(aclk), .en(en), .num(any_reg), .den(os_reg), .quo(qay));

    bjv_pkg::tail_t td_reg [TQ];

    always_ff @(posedge aclk) begin
        if (en) begin
            td_reg[0] <= ov_reg;
            for (int k = 1; k < TQ; k++) begin
                td_reg[k] <= td_reg[k-1];
            end
        end
    end

    // result assembly
    bjv_pkg::tail_t  tl;
    bjv_pkg::result_t res_next;

    assign tl = td_reg[TQ-1];

    always_comb begin
        res_next.vel_x = bjv_pkg::horz_vel(tl.m.dx_neg, tl.m.dx_nz, tl.s_zero, tl.ovx, qvx);
        res_next.vel_y = bjv_pkg::horz_vel(tl.m.dy_neg, tl.m.dy_nz, tl.s_zero, tl.ovy, qvy);
        res_next.vel_z = (tl.vz > SR'(bjv_pkg::H_CAP)) ? bjv_pkg::H_CAP : tl.vz[PW-1:0];
        res_next.apex_x = bjv_pkg::apex_pos(tl.s_zero, tl.m.dx_neg, tl.m.sx, qax);
        res_next.apex_y = bjv_pkg::apex_pos(tl.s_zero, tl.m.dy_neg, tl.m.sy, qay);
        res_next.apex_z = bjv_pkg::clamp_pos($signed({{2{tl.m.sz[PW-1]}}, tl.m.sz})
                                             + $signed({2'b00, tl.m.h}));
        res_next.used_height = tl.m.h;
    end

    // two-entry output buffer
    bjv_pkg::result_t buf_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= res_next;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = bjv_pkg::OUT_DATA_W'(buf_reg[rd_ptr_reg]);

endmodule

// File: sv/bjv_checker.sv
// ----------------------------------------------------------------------------
// bjv_checker
// port-level checks for the ballistic jump velocity unit
// ----------------------------------------------------------------------------
module bjv_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic [bjv_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready
);

    // buffer empty and open after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && s_tready)
        else $error("output buffer not empty after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input held off only with results waiting
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("request held off with no result waiting");

    // zero apex height means zero upward speed
    a_zero_height: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[162:140] == '0) |-> (m_tdata[70:48] == '0))
        else $error("upward speed without apex height");

endmodule

bind ballistic_jump_velocity_unit bjv_checker u_bjv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for ballistic_jump_velocity_unit. Drives jump requests over the
// input stream and register writes over the config channel, predicts each
// launch velocity, apex point and used height in integer math, and checks
// every returned result in order. Covers directed corner requests, random
// requests under several register settings, random idling on both sides, a
// long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = bjv_pkg::POS_W;
    localparam int VW = bjv_pkg::VEL_W;
    localparam longint unsigned HEIGHT_CAP = 64'd8388607;
    localparam int DRAIN_CYCLES = bjv_pkg::PIPE_LAT + 20;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic signed [PW-1:0] sx, sy, sz, gx, gy, gz;
        logic [PW-1:0]        minh;
    } jump_t;

    logic                              aclk;
    logic                              aresetn;
    logic [bjv_pkg::IN_DATA_W-1:0]     s_tdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [bjv_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [bjv_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [bjv_pkg::CFG_W-1:0]         cfg_data;

    bjv_pkg::result_t launch_q[$];
    longint unsigned gravity_q;
    longint unsigned speed_q;
    int             n_errors;
    bit             tx_idle_en;
    bit             rx_idle_en;
    int             hold_cycles;
    int             rx_stall;
    int             quiet_cycles;

    ballistic_jump_velocity_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint mul_div(input longint num, input longint unsigned mul,
                                       input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (mag * mul) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint horz_speed(input longint d, input longint unsigned sg,
                                          input longint unsigned s);
        if (s == 0) return (d > 0) ? 8388607 : ((d < 0) ? -8388608 : 0);
        return clamp(mul_div(d, sg, s), -8388608, 8388607);
    endfunction

    function automatic bjv_pkg::result_t predict_launch(input jump_t j);
        longint sx, sy, sz, dx, dy, rise, ax, ay, az;
        longint unsigned g, v, d2, den, lim, hang, h, e, s0, s1, s, sg, vz;
        bjv_pkg::result_t r;
        g = (gravity_q == 0) ? 1 : gravity_q;
        v = (speed_q == 0) ? 1 : speed_q;
        sx = longint'(j.sx);
        sy = longint'(j.sy);
        sz = longint'(j.sz);
        dx = longint'(j.gx) - sx;
        dy = longint'(j.gy) - sy;
        rise = longint'(j.gz) - sz;
        d2 = longint'(dx * dx) + longint'(dy * dy);
        den = 8 * v * v;
        lim = (den * HEIGHT_CAP + g - 1) / g;
        hang = (d2 >= lim) ? HEIGHT_CAP : (g * d2) / den;
        h = {41'd0, j.minh};
        if (hang > h) h = hang;
        if (rise > 0 && longint'(h) < rise) h = rise;
        if (h > HEIGHT_CAP) h = HEIGHT_CAP;
        e = longint'(h) - rise;
        s0 = isqrt(h << 32);
        s1 = isqrt(e << 32);
        s = s0 + s1;
        sg = isqrt(g << 31);
        vz = isqrt(2 * g * h);
        if (vz > HEIGHT_CAP) vz = HEIGHT_CAP;
        ax = sx;
        ay = sy;
        if (s != 0) begin
            ax = clamp(sx + mul_div(dx, s0, s), -4194304, 4194303);
            ay = clamp(sy + mul_div(dy, s0, s), -4194304, 4194303);
        end
        az = clamp(sz + longint'(h), -4194304, 4194303);
        r.vel_x = VW'(horz_speed(dx, sg, s));
        r.vel_y = VW'(horz_speed(dy, sg, s));
        r.vel_z = PW'(vz);
        r.apex_x = PW'(ax);
        r.apex_y = PW'(ay);
        r.apex_z = PW'(az);
        r.used_height = PW'(h);
        return r;
    endfunction

    // receiver: random stall bursts and commanded hold-off
    initial begin
        m_tready = 1'b0;
        rx_stall = 0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                rx_stall = $urandom_range(0, 5);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        bjv_pkg::result_t got;
        bjv_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = bjv_pkg::result_t'(m_tdata[$bits(bjv_pkg::result_t)-1:0]);
            if (launch_q.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                n_errors++;
            end else begin
                want = launch_q.pop_front();
                if (got.vel_x !== want.vel_x) begin
                    $error("vel_x expected %h got %h", want.vel_x, got.vel_x);
                    n_errors++;
                end
                if (got.vel_y !== want.vel_y) begin
                    $error("vel_y expected %h got %h", want.vel_y, got.vel_y);
                    n_errors++;
                end
                if (got.vel_z !== want.vel_z) begin
                    $error("vel_z expected %h got %h", want.vel_z, got.vel_z);
                    n_errors++;
                end
                if (got.apex_x !== want.apex_x) begin
                    $error("apex_x expected %h got %h", want.apex_x, got.apex_x);
                    n_errors++;
                end
                if (got.apex_y !== want.apex_y) begin
                    $error("apex_y expected %h got %h", want.apex_y, got.apex_y);
                    n_errors++;
                end
                if (got.apex_z !== want.apex_z) begin
                    $error("apex_z expected %h got %h", want.apex_z, got.apex_z);
                    n_errors++;
                end
                if (got.used_height !== want.used_height) begin
                    $error("used_height expected %h got %h",
                           want.used_height, got.used_height);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_jump(input jump_t j);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {7'd0, j.minh, j.gz, j.gy, j.gx, j.sz, j.sy, j.sx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        launch_q.push_back(predict_launch(j));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (launch_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bjv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bjv_pkg::CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == bjv_pkg::CFG_GRAVITY) gravity_q = 64'(val);
        else speed_q = 64'(val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [PW-1:0] near_pos(input logic signed [PW-1:0] p,
                                                       input int span);
        return PW'(clamp(longint'(p) + $urandom_range(0, 2 * span) - span,
                         -4194304, 4194303));
    endfunction

    function automatic jump_t random_jump();
        jump_t j;
        int span;
        j.sx = PW'($urandom);
        j.sy = PW'($urandom);
        j.sz = PW'($urandom);
        if ($urandom_range(0, 9) < 7) begin
            span = (1 << $urandom_range(2, 20));
            j.gx = near_pos(j.sx, span);
            j.gy = near_pos(j.sy, span);
            j.gz = near_pos(j.sz, span);
            j.minh = ($urandom_range(0, 3) == 0) ? '0 : PW'($urandom_range(0, span));
        end else begin
            j.gx = PW'($urandom);
            j.gy = PW'($urandom);
            j.gz = PW'($urandom);
            j.minh = PW'($urandom);
        end
        return j;
    endfunction

    function automatic jump_t make_jump(input longint sx, sy, sz, gx, gy, gz, mh);
        jump_t j;
        j.sx = PW'(sx); j.sy = PW'(sy); j.sz = PW'(sz);
        j.gx = PW'(gx); j.gy = PW'(gy); j.gz = PW'(gz);
        j.minh = PW'(mh);
        return j;
    endfunction

    task automatic test_directed();
        send_jump(make_jump(0, 0, 0, 0, 0, 0, 0));
        send_jump(make_jump(100, -200, 5, 101, -200, 5, 0));
        send_jump(make_jump(100, -200, 5, 100, -201, 5, 0));
        send_jump(make_jump(0, 0, 0, 0, 0, 0, 8388607));
        send_jump(make_jump(-4194304, -4194304, -4194304, 4194303, 4194303, 4194303, 0));
        send_jump(make_jump(4194303, 4194303, 4194303, -4194304, -4194304, -4194304, 0));
        send_jump(make_jump(4194303, -4194304, 0, -4194304, 4194303, 0, 8388607));
        send_jump(make_jump(0, 0, 0, 25600, 0, 76800, 256));
        send_jump(make_jump(0, 0, 0, -25600, 12800, -76800, 1024));
        send_jump(make_jump(0, 0, 0, 0, 0, 51200, 0));
        send_jump(make_jump(0, 0, 4194303, 0, 0, 4194303, 8388607));
        send_jump(make_jump(0, 0, -4194304, 0, 0, -4194304, 8388607));
        send_jump(make_jump(-4194304, 0, 0, 4194303, 0, 0, 0));
        send_jump(make_jump(0, 4194303, 0, 0, -4194304, 0, 0));
        send_jump(make_jump(1000, 2000, 0, 90000, -40000, 3000, 5000));
        wait_idle();
    endtask

    task automatic test_random(input int count);
        repeat (count) send_jump(random_jump());
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        repeat (150) send_jump(random_jump());
        wait_idle();
    endtask

    task automatic test_drain_pause();
        repeat (20) send_jump(random_jump());
        wait_idle();
        repeat (20) send_jump(random_jump());
        wait_idle();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = bjv_pkg::CFG_GRAVITY;
        cfg_data = '0;
        gravity_q = 64'(bjv_pkg::GRAVITY_RST);
        speed_q = 64'(bjv_pkg::SPEED_RST);
        n_errors = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(150);
        test_backpressure();
        test_drain_pause();

        write_reg(bjv_pkg::CFG_GRAVITY, 18'd262143);
        write_reg(bjv_pkg::CFG_MAX_HORZ_SPEED, 18'd1);
        test_directed();
        test_random(200);

        write_reg(bjv_pkg::CFG_GRAVITY, 18'd0);
        write_reg(bjv_pkg::CFG_MAX_HORZ_SPEED, 18'd262143);
        test_directed();
        test_random(200);

        write_reg(bjv_pkg::CFG_GRAVITY, 18'd1);
        write_reg(bjv_pkg::CFG_MAX_HORZ_SPEED, 18'd0);
        test_random(150);

        write_reg(bjv_pkg::CFG_GRAVITY, bjv_pkg::CFG_W'($urandom_range(1, 262143)));
        write_reg(bjv_pkg::CFG_MAX_HORZ_SPEED, bjv_pkg::CFG_W'($urandom_range(1, 262143)));
        test_random(150);

        write_reg(bjv_pkg::CFG_GRAVITY, bjv_pkg::GRAVITY_RST);
        write_reg(bjv_pkg::CFG_MAX_HORZ_SPEED, bjv_pkg::SPEED_RST);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random(200);

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
